[rtl/core/opi_pkg.sv]
package opi_pkg;

  localparam int TAG_W = 32;
  localparam int LEN_W = 16;
  localparam int TIME_W = 32;
  localparam int DRAW_W = 16;
  localparam int LAG_W = 20;
  localparam int PCT_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  localparam int MAX_RESULTS = 16;
  localparam int REL_W = $clog2(MAX_RESULTS + 1);

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LAG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REORDER = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
    logic [TIME_W-1:0] due;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic push;
    logic swap;
  } cell_ctrl_t;

  function automatic logic chance_below(input logic [DRAW_W-1:0] draw,
                                        input logic [PCT_W-1:0] pct);
    logic [DRAW_W+PCT_W-1:0] scaled;
    scaled = {{PCT_W{1'b0}}, draw} * (DRAW_W + PCT_W)'(100);
    return scaled < {pct, {DRAW_W{1'b0}}};
  endfunction

endpackage

[rtl/core/opi_in_if.sv]
interface opi_in_if
  import opi_pkg::*;
  ();
  logic valid;
  logic ready;
  logic command;
  logic [TAG_W-1:0] packet_tag;
  logic [LEN_W-1:0] packet_length;
  logic [DRAW_W-1:0] draw_loss;
  logic [DRAW_W-1:0] draw_reorder;
  logic [DRAW_W-1:0] draw_duplicate;

  modport source (
    output valid, command, packet_tag, packet_length, draw_loss, draw_reorder,
      draw_duplicate,
    input ready
  );
  modport sink (
    input valid, command, packet_tag, packet_length, draw_loss, draw_reorder,
      draw_duplicate,
    output ready
  );
endinterface

[rtl/core/opi_out_if.sv]
interface opi_out_if
  import opi_pkg::*;
  ();
  logic valid;
  logic ready;
  logic [TAG_W-1:0] out_tag;
  logic [LEN_W-1:0] out_length;
  logic last_of_run;

  modport source (
    output valid, out_tag, out_length, last_of_run,
    input ready
  );
  modport sink (
    input valid, out_tag, out_length, last_of_run,
    output ready
  );
endinterface

[rtl/core/opi_cell.sv]
module opi_cell
  import opi_pkg::*;
#(
  parameter int CW = 5,
  parameter int INDEX = 0
) (
  input  logic clk,
  input  cell_ctrl_t ctrl,
  input  logic [CW-1:0] pos,
  input  entry_t bcast,
  input  entry_t from_prev,
  input  entry_t from_next,
  output entry_t q
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      q <= from_next;
    end else if (ctrl.push && pos == CW'(INDEX)) begin
      q <= bcast;
    end else if (ctrl.swap && pos == CW'(INDEX)) begin
      q.tag <= from_prev.tag;
      q.len <= from_prev.len;
      q.due <= bcast.due;
    end else if (ctrl.swap && pos == CW'(INDEX + 1)) begin
      q.tag <= bcast.tag;
      q.len <= bcast.len;
    end
  end

endmodule

[rtl/core/outbound_packet_impairment.sv]
// Network impairment stage for outbound packet descriptors: drops, delays,
// duplicates and reorders packets under four percentage/lag registers. A send
// with lag at most IMMEDIATE_LAG_LIMIT is accepted and its one or two results
// leave through the output register; a queued send gives no result; a dropped
// send gives none either. A tick releases up to 16 due packets from the delay
// queue, a row of cells that shifts one entry out of its head per cycle while
// the output is free. Results pass through a single output register, which
// back-pressure stalls. Configuration must be written only while the block is
// idle; the user is bound to this, as the block itself does not enforce it.
module outbound_packet_impairment
  import opi_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int IMMEDIATE_LAG_LIMIT = 100
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  opi_in_if.sink cmd,
  opi_out_if.source tx
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EMIT = 3'd1;
  localparam logic [2:0] S_PUSH = 3'd2;
  localparam logic [2:0] S_DUP = 3'd3;
  localparam logic [2:0] S_REL = 3'd4;

  logic [LAG_W-1:0] lag_ticks;
  logic [PCT_W-1:0] loss_percent;
  logic [PCT_W-1:0] duplicate_percent;
  logic [PCT_W-1:0] reorder_percent;

  logic [2:0] state;
  logic [TIME_W-1:0] time_now;
  logic [CW-1:0] count;
  logic [REL_W-1:0] rel_n;
  logic second;
  logic dup;
  logic reo;
  entry_t pkt;

  logic out_valid;
  logic [TAG_W-1:0] out_tag;
  logic [LEN_W-1:0] out_length;
  logic out_last;

  cell_ctrl_t ctrl;
  entry_t cells [QUEUE_DEPTH];

  logic accept;
  logic out_free;
  logic queue_room;
  logic [TIME_W-1:0] head_age;
  logic [TIME_W-1:0] next_age;
  logic head_due;
  logic next_due;
  logic lag_immediate;
  logic lost;

  assign cmd.ready = (state == S_IDLE);
  assign accept = cmd.valid && cmd.ready;
  assign out_free = !out_valid || tx.ready;
  assign queue_room = count < CW'(QUEUE_DEPTH);
  assign lag_immediate = lag_ticks <= LAG_W'(IMMEDIATE_LAG_LIMIT);
  assign lost = chance_below(cmd.draw_loss, loss_percent);

  // serial-number compare on the due time
  assign head_age = time_now - cells[0].due;
  assign next_age = time_now - cells[1].due;
  assign head_due = (count != '0) && (rel_n < REL_W'(MAX_RESULTS)) &&
                    !head_age[TIME_W-1];
  assign next_due = (count > CW'(1)) && (rel_n < REL_W'(MAX_RESULTS - 1)) &&
                    !next_age[TIME_W-1];

  assign tx.valid = out_valid;
  assign tx.out_tag = out_tag;
  assign tx.out_length = out_length;
  assign tx.last_of_run = out_last;

  always_comb begin
    ctrl = '0;
    case (state)
      S_PUSH: begin
        ctrl.swap = queue_room && reo && (count != '0);
        ctrl.push = queue_room && !(reo && (count != '0));
      end
      S_DUP: ctrl.push = queue_room;
      S_REL: ctrl.shift = head_due && out_free;
      default: ctrl = '0;
    endcase
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    if (g == 0) begin : g_first
      assign prev_e = pkt;
    end else begin : g_mid
      assign prev_e = cells[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign next_e = cells[g];
    end else begin : g_inner
      assign next_e = cells[g+1];
    end
    opi_cell #(.CW(CW), .INDEX(g)) u_cell (
      .clk(clk),
      .ctrl(ctrl),
      .pos(count),
      .bcast(pkt),
      .from_prev(prev_e),
      .from_next(next_e),
      .q(cells[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lag_ticks <= '0;
      loss_percent <= '0;
      duplicate_percent <= '0;
      reorder_percent <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAG: lag_ticks <= cfg_data;
        REG_LOSS: loss_percent <= cfg_data[PCT_W-1:0];
        REG_DUP: duplicate_percent <= cfg_data[PCT_W-1:0];
        REG_REORDER: reorder_percent <= cfg_data[PCT_W-1:0];
        default: lag_ticks <= lag_ticks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pkt.tag <= cmd.packet_tag;
      pkt.len <= cmd.packet_length;
      pkt.due <= time_now + {{(TIME_W - LAG_W){1'b0}}, lag_ticks};
      dup <= chance_below(cmd.draw_duplicate, duplicate_percent);
      reo <= chance_below(cmd.draw_reorder, reorder_percent);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      time_now <= '0;
      count <= '0;
      rel_n <= '0;
      second <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && tx.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.command == CMD_TICK) begin
              time_now <= time_now + TIME_W'(1);
              rel_n <= '0;
              state <= S_REL;
            end else if (!lost) begin
              second <= 1'b0;
              state <= lag_immediate ? S_EMIT : S_PUSH;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_tag <= pkt.tag;
            out_length <= pkt.len;
            out_last <= second || !dup;
            if (second || !dup) begin
              state <= S_IDLE;
            end else begin
              second <= 1'b1;
            end
          end
        end
        S_PUSH: begin
          if (queue_room) begin
            count <= count + CW'(1);
          end
          state <= dup ? S_DUP : S_IDLE;
        end
        S_DUP: begin
          if (queue_room) begin
            count <= count + CW'(1);
          end
          state <= S_IDLE;
        end
        S_REL: begin
          if (!head_due) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid <= 1'b1;
            out_tag <= cells[0].tag;
            out_length <= cells[0].len;
            out_last <= !next_due;
            count <= count - CW'(1);
            rel_n <= rel_n + REL_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_shift_emits: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift |=> tx.valid && count == $past(count) - CW'(1))
    else $error("head shifted without a result");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PUSH || state == S_DUP) && count == CW'(QUEUE_DEPTH)) |=>
      count == CW'(QUEUE_DEPTH))
    else $error("push into a full queue");

endmodule

[dv/tb_outbound_packet_impairment.sv]
module tb_outbound_packet_impairment
  import opi_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int LAG_LIMIT = 100;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic command;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] length;
    logic [DRAW_W-1:0] draw_loss;
    logic [DRAW_W-1:0] draw_reorder;
    logic [DRAW_W-1:0] draw_dup;
  } cmd_req_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] length;
    logic last;
  } tx_pkt_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  opi_in_if cmd_bus ();
  opi_out_if tx_bus ();

  outbound_packet_impairment #(
    .QUEUE_DEPTH(DEPTH),
    .IMMEDIATE_LAG_LIMIT(LAG_LIMIT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd_bus.sink),
    .tx(tx_bus.source)
  );

  // shadow of the delay queue and registers
  logic [TAG_W-1:0] slot_tag [DEPTH];
  logic [LEN_W-1:0] slot_len [DEPTH];
  logic [TIME_W-1:0] slot_due [DEPTH];
  int q_head = 0;
  int q_fill = 0;
  logic [TIME_W-1:0] model_now = '0;
  logic [LAG_W-1:0] model_lag = '0;
  logic [PCT_W-1:0] model_loss = '0;
  logic [PCT_W-1:0] model_dup = '0;
  logic [PCT_W-1:0] model_reorder = '0;

  tx_pkt_t pending_tx [$];
  bit steady = 1'b0;
  int error_count = 0;
  int request_count = 0;
  int tick_count = 0;
  int tx_checked = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic bit draw_hits(input logic [DRAW_W-1:0] draw,
                                   input logic [PCT_W-1:0] pct);
    return (32'(draw) * 32'd100) < (32'(pct) << 16);
  endfunction

  function automatic void enqueue_entry(input logic [TAG_W-1:0] tag,
                                        input logic [LEN_W-1:0] length,
                                        input logic [TIME_W-1:0] due);
    int slot;
    if (q_fill >= DEPTH) return;
    slot = (q_head + q_fill) % DEPTH;
    slot_tag[slot] = tag;
    slot_len[slot] = length;
    slot_due[slot] = due;
    q_fill++;
  endfunction

  function automatic void impair_request(input cmd_req_t r);
    tx_pkt_t burst [$];
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] age;
    logic [TAG_W-1:0] old_tag;
    logic [LEN_W-1:0] old_len;
    int tail;
    if (r.command == CMD_SEND) begin
      if (!draw_hits(r.draw_loss, model_loss)) begin
        if (model_lag > LAG_LIMIT) begin
          due = model_now + TIME_W'(model_lag);
          if (q_fill < DEPTH) begin
            if (draw_hits(r.draw_reorder, model_reorder) && q_fill > 0) begin
              // new packet takes the tail slot and its due time
              tail = (q_head + q_fill - 1) % DEPTH;
              old_tag = slot_tag[tail];
              old_len = slot_len[tail];
              slot_tag[tail] = r.tag;
              slot_len[tail] = r.length;
              enqueue_entry(old_tag, old_len, due);
            end else begin
              enqueue_entry(r.tag, r.length, due);
            end
          end
          if (draw_hits(r.draw_dup, model_dup)) enqueue_entry(r.tag, r.length, due);
        end else begin
          burst.push_back('{r.tag, r.length, 1'b0});
          if (draw_hits(r.draw_dup, model_dup)) burst.push_back('{r.tag, r.length, 1'b0});
        end
      end
    end else begin
      model_now++;
      while (q_fill > 0 && burst.size() < MAX_RESULTS) begin
        // serial-number compare on the due time
        age = model_now - slot_due[q_head];
        if (age[TIME_W-1]) break;
        burst.push_back('{slot_tag[q_head], slot_len[q_head], 1'b0});
        q_head = (q_head + 1) % DEPTH;
        q_fill--;
      end
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) pending_tx.push_back(burst[i]);
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic check_tx();
    tx_pkt_t want;
    if (pending_tx.size() == 0) begin
      $display("%0t: unexpected packet, expected none, actual tag %h len %h last %b",
               $time, tx_bus.out_tag, tx_bus.out_length, tx_bus.last_of_run);
      error_count++;
    end else begin
      want = pending_tx.pop_front();
      compare_field("out_tag", want.tag, tx_bus.out_tag);
      compare_field("out_length", 32'(want.length), 32'(tx_bus.out_length));
      compare_field("last_of_run", 32'(want.last), 32'(tx_bus.last_of_run));
      tx_checked++;
    end
  endtask

  initial begin
    tx_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tx_bus.valid === 1'b1 && tx_bus.ready === 1'b1) check_tx();
      tx_bus.ready <= steady || ($urandom_range(99) >= 8);
    end
  end

  task automatic send_request(input cmd_req_t r);
    if (!steady && $urandom_range(99) < 8) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.command <= r.command;
    cmd_bus.packet_tag <= r.tag;
    cmd_bus.packet_length <= r.length;
    cmd_bus.draw_loss <= r.draw_loss;
    cmd_bus.draw_reorder <= r.draw_reorder;
    cmd_bus.draw_duplicate <= r.draw_dup;
    @(posedge clk);
    while (cmd_bus.ready !== 1'b1) @(posedge clk);
    impair_request(r);
    request_count++;
    if (r.command == CMD_TICK) tick_count++;
  endtask

  function automatic cmd_req_t send_desc(input logic [TAG_W-1:0] tag,
                                         input logic [LEN_W-1:0] length,
                                         input logic [DRAW_W-1:0] dl,
                                         input logic [DRAW_W-1:0] dr,
                                         input logic [DRAW_W-1:0] dd);
    return '{CMD_SEND, tag, length, dl, dr, dd};
  endfunction

  function automatic cmd_req_t random_send();
    return send_desc($urandom, LEN_W'($urandom_range(1, 65535)),
                     DRAW_W'($urandom_range(0, 65535)), DRAW_W'($urandom_range(0, 65535)),
                     DRAW_W'($urandom_range(0, 65535)));
  endfunction

  function automatic cmd_req_t random_tick();
    cmd_req_t r;
    r = random_send();
    r.command = CMD_TICK;
    return r;
  endfunction

  task automatic drain_queue();
    while (q_fill != 0) send_request(random_tick());
  endtask

  // stop sending and wait until every expected packet is out
  task automatic settle();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_tx.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_LAG: model_lag = data[LAG_W-1:0];
      REG_LOSS: model_loss = data[PCT_W-1:0];
      REG_DUP: model_dup = data[PCT_W-1:0];
      REG_REORDER: model_reorder = data[PCT_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic configure(input logic [LAG_W-1:0] lag, input logic [PCT_W-1:0] loss,
                           input logic [PCT_W-1:0] dup, input logic [PCT_W-1:0] reorder);
    settle();
    cfg_we <= 1'b1;
    put_reg(REG_LAG, CFG_DATA_W'(lag));
    put_reg(REG_LOSS, CFG_DATA_W'(loss));
    put_reg(REG_DUP, CFG_DATA_W'(dup));
    put_reg(REG_REORDER, CFG_DATA_W'(reorder));
    cfg_we <= 1'b0;
  endtask

  task automatic test_immediate_path();
    configure('0, '0, '0, '0);
    send_request(send_desc('0, 16'd1, '0, '0, '0));
    send_request(send_desc('1, '1, '1, '1, '1));
    send_request(random_tick());
    // threshold draws at fifty percent, lag at the immediate limit
    configure(LAG_W'(LAG_LIMIT), PCT_W'(50), PCT_W'(50), '0);
    send_request(send_desc(32'hA5A5_0001, 16'd60, 16'd32767, '0, '0));
    send_request(send_desc(32'h5A5A_0002, 16'd1514, 16'd32768, '0, 16'd32767));
    send_request(send_desc(32'hC3C3_0003, 16'd9000, '1, '0, 16'd32768));
    configure('0, PCT_W'(127), PCT_W'(127), PCT_W'(127));
    send_request(send_desc(32'hDEAD_0004, 16'd256, '1, '1, '1));
    configure('0, PCT_W'(100), '0, '0);
    send_request(send_desc(32'hDEAD_0005, 16'd256, '1, '0, '0));
    configure('0, '0, PCT_W'(100), '0);
    send_request(send_desc(32'h0F0F_0006, 16'd128, '0, '0, '1));
  endtask

  task automatic test_random_immediate();
    configure(LAG_W'($urandom_range(0, LAG_LIMIT)), PCT_W'($urandom_range(0, 30)),
              PCT_W'($urandom_range(0, 60)), PCT_W'($urandom_range(0, 100)));
    repeat (6) begin
      send_request(random_send());
      repeat ($urandom_range(0, 1)) send_request(random_tick());
    end
  endtask

  // queue fills to the brim, then one long tick run releases it all
  task automatic test_delay_queue();
    configure(LAG_W'(LAG_LIMIT + 1), '0, PCT_W'(50), PCT_W'(50));
    send_request(send_desc(32'h1111_0001, 16'd64, '0, '1, '1));
    send_request(send_desc(32'h2222_0002, 16'd1500, '0, '0, '1));
    repeat (3) send_request(random_tick());
    send_request(send_desc(32'h3333_0003, 16'd40, '0, '0, '0));
    repeat (5) send_request(send_desc($urandom, 16'd100, '0, '1, '0));
    send_request(send_desc(32'h7777_0015, 16'd200, '0, '0, '1));
    // one slot left: packet fits, duplicate dropped
    send_request(send_desc(32'h7777_0016, 16'd300, '0, '1, '0));
    // full: no swap, packet and duplicate dropped
    send_request(send_desc(32'h7777_0017, 16'd400, '0, '0, '0));
    steady = 1'b1;
    drain_queue();
    steady = 1'b0;
  endtask

  // entries never come due within the run, so this stays last
  task automatic test_long_lag();
    configure('1, PCT_W'(25), PCT_W'(50), PCT_W'(50));
    repeat (2) send_request(random_send());
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_LAG;
    cfg_data <= '0;
    cmd_bus.valid <= 1'b0;
    cmd_bus.command <= CMD_SEND;
    cmd_bus.packet_tag <= '0;
    cmd_bus.packet_length <= '0;
    cmd_bus.draw_loss <= '0;
    cmd_bus.draw_reorder <= '0;
    cmd_bus.draw_duplicate <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_immediate_path();
    test_random_immediate();
    test_delay_queue();
    test_long_lag();
    settle();
    $display("run covered %0d requests (%0d ticks), %0d packets checked, %0d register writes",
             request_count, tick_count, tx_checked, reg_writes);
    $display("immediate, delayed, reordered, duplicated, lost and queue-full paths exercised");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
